>>> src/vgl_pkg.sv
`timescale 1ns / 1ps

package vgl_pkg;

    // Default grid dimensions.
    localparam int X_SIZE_DEF = 256;
    localparam int Y_SIZE_DEF = 64;
    localparam int Z_SIZE_DEF = 256;

    // Fixed field widths of the request and response channels.
    localparam int XZ_W   = 10;
    localparam int Y_W    = 8;
    localparam int TYPE_W = 8;
    localparam int SPAN_W = 6;

    // Entries in the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Request operation codes.
    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } op_t;

    // One response, as held in the output register.
    typedef struct packed {
        logic              in_range;
        logic [TYPE_W-1:0] cell_type;
        logic              lit;
        logic              written;
        logic              light_changed;
        logic [SPAN_W-1:0] light_span_low;
        logic [SPAN_W-1:0] light_span_high;
    } rsp_t;

endpackage

>>> src/vgl_cmd_if.sv
`timescale 1ns / 1ps

interface vgl_cmd_if
    import vgl_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [XZ_W-1:0]   cell_x;
    logic signed [Y_W-1:0]    cell_y;
    logic signed [XZ_W-1:0]   cell_z;
    logic        [TYPE_W-1:0] new_type;

    modport source (
        output valid, op, cell_x, cell_y, cell_z, new_type,
        input  ready
    );

    modport sink (
        input  valid, op, cell_x, cell_y, cell_z, new_type,
        output ready
    );
endinterface

>>> src/vgl_rsp_if.sv
`timescale 1ns / 1ps

interface vgl_rsp_if
    import vgl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              in_range;
    logic [TYPE_W-1:0] cell_type;
    logic              lit;
    logic              written;
    logic              light_changed;
    logic [SPAN_W-1:0] light_span_low;
    logic [SPAN_W-1:0] light_span_high;

    modport source (
        output valid, in_range, cell_type, lit, written, light_changed,
               light_span_low, light_span_high,
        input  ready
    );

    modport sink (
        input  valid, in_range, cell_type, lit, written, light_changed,
               light_span_low, light_span_high,
        output ready
    );
endinterface

>>> src/vgl_front.sv
`timescale 1ns / 1ps

module vgl_front
    import vgl_pkg::*;
#(
    parameter int X_SIZE = X_SIZE_DEF,
    parameter int Y_SIZE = Y_SIZE_DEF,
    parameter int Z_SIZE = Z_SIZE_DEF,
    localparam int YIDX_W = $clog2(Y_SIZE),
    localparam int XIDX_W = $clog2(X_SIZE),
    localparam int ZIDX_W = $clog2(Z_SIZE),
    localparam int COL_W  = $clog2(X_SIZE * Z_SIZE),
    localparam int ENT_W  = 2 + YIDX_W + COL_W + TYPE_W
)
(
    vgl_cmd_if.sink          cmd,
    input  logic             clearing,
    input  logic             q_full,
    output logic             q_push,
    output logic [ENT_W-1:0] q_data
);

    // Layout of one queue entry; the back end uses the same layout.
    typedef struct packed {
        logic              op;
        logic              in_range;
        logic [YIDX_W-1:0] y_idx;
        logic [COL_W-1:0]  col;
        logic [TYPE_W-1:0] new_type;
    } ent_t;

    ent_t              ent;
    logic              x_ok;
    logic              y_ok;
    logic              z_ok;
    logic [XIDX_W-1:0] x_idx;
    logic [ZIDX_W-1:0] z_idx;

    // Take a request whenever the queue has room and the store is usable.
    assign cmd.ready = !clearing && !q_full;
    assign q_push    = cmd.valid && cmd.ready;

    // Range check: the sign bit must be clear and the magnitude below the size.
    assign x_ok = !cmd.cell_x[XZ_W-1] && (32'(cmd.cell_x[XZ_W-2:0]) < 32'(X_SIZE));
    assign y_ok = !cmd.cell_y[Y_W-1]  && (32'(cmd.cell_y[Y_W-2:0])  < 32'(Y_SIZE));
    assign z_ok = !cmd.cell_z[XZ_W-1] && (32'(cmd.cell_z[XZ_W-2:0]) < 32'(Z_SIZE));

    assign x_idx = cmd.cell_x[XIDX_W-1:0];
    assign z_idx = cmd.cell_z[ZIDX_W-1:0];

    // Classify the request and form the column address x + z * X_SIZE.
    always_comb
    begin
        ent.op       = cmd.op;
        ent.in_range = x_ok && y_ok && z_ok;
        ent.y_idx    = cmd.cell_y[YIDX_W-1:0];
        ent.col      = COL_W'(32'(x_idx) + 32'(z_idx) * 32'(X_SIZE));
        ent.new_type = cmd.new_type;
    end

    assign q_data = ent;

endmodule

>>> src/vgl_queue.sv
`timescale 1ns / 1ps

module vgl_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/vgl_back.sv
`timescale 1ns / 1ps

module vgl_back
    import vgl_pkg::*;
#(
    parameter int X_SIZE = X_SIZE_DEF,
    parameter int Y_SIZE = Y_SIZE_DEF,
    parameter int Z_SIZE = Z_SIZE_DEF,
    localparam int YIDX_W    = $clog2(Y_SIZE),
    localparam int COL_COUNT = X_SIZE * Z_SIZE,
    localparam int COL_W     = $clog2(COL_COUNT),
    localparam int ENT_W     = 2 + YIDX_W + COL_W + TYPE_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  logic [ENT_W-1:0] q_data,
    output logic             q_pop,
    output logic             clearing,
    vgl_rsp_if.source        rsp
);

    // Same layout as the front end's queue entry.
    typedef struct packed {
        logic              op;
        logic              in_range;
        logic [YIDX_W-1:0] y_idx;
        logic [COL_W-1:0]  col;
        logic [TYPE_W-1:0] new_type;
    } ent_t;

    typedef logic [Y_SIZE-1:0][TYPE_W-1:0] col_word_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Highest solid y of a column, looking at y = 1 and above; 0 when none.
    function automatic logic [YIDX_W-1:0] col_depth(input col_word_t w);
        logic [YIDX_W-1:0] d;
        d = '0;
        for (int i = 1; i < Y_SIZE; i++)
        begin
            if (w[i] != '0)
            begin
                d = YIDX_W'(i);
            end
        end
        return d;
    endfunction

    // One word per (x,z) column holds all cells of that column.
    col_word_t         col_mem [COL_COUNT];
    col_word_t         rdata_reg;

    state_t            state_reg;
    logic [COL_W-1:0]  clr_reg;
    ent_t              cur_reg;
    ent_t              q_ent;
    logic              out_valid_reg;
    rsp_t              out_reg;
    rsp_t              out_next;

    logic              go;
    logic              do_write;
    logic [TYPE_W-1:0] old_cell;
    col_word_t         new_word;
    logic [YIDX_W-1:0] old_depth;
    logic [YIDX_W-1:0] new_depth;
    logic [YIDX_W-1:0] span_lo;
    logic [YIDX_W-1:0] span_hi;

    logic              mem_we;
    logic [COL_W-1:0]  mem_waddr;
    col_word_t         mem_wdata;

    assign q_ent    = q_data;
    assign clearing = (state_reg == ST_CLEAR);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign go       = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    // Read-modify-write of the column and depth recomputation.
    always_comb
    begin
        old_cell  = rdata_reg[cur_reg.y_idx];
        do_write  = (cur_reg.op == OP_SET) && cur_reg.in_range &&
                    (old_cell != cur_reg.new_type);
        new_word  = rdata_reg;
        if (do_write)
        begin
            new_word[cur_reg.y_idx] = cur_reg.new_type;
        end
        old_depth = col_depth(rdata_reg);
        new_depth = col_depth(new_word);
        span_lo   = (old_depth < new_depth) ? old_depth : new_depth;
        span_hi   = (old_depth < new_depth) ? new_depth : old_depth;

        out_next                 = '0;
        out_next.in_range        = cur_reg.in_range;
        out_next.lit             = 1'b1;
        if (cur_reg.in_range)
        begin
            out_next.cell_type = new_word[cur_reg.y_idx];
            out_next.lit       = (cur_reg.y_idx >= new_depth);
        end
        out_next.written         = do_write;
        if (do_write && (old_depth != new_depth))
        begin
            out_next.light_changed   = 1'b1;
            out_next.light_span_low  = SPAN_W'(span_lo);
            out_next.light_span_high = SPAN_W'(span_hi);
        end
    end

    // The clearing pass and completed writes share the memory write port.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg.col;
        mem_wdata = new_word;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (go && do_write)
        begin
            mem_we = 1'b1;
        end
    end

    // Column memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            col_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop)
        begin
            rdata_reg <= col_mem[q_ent.col];
        end
    end

    // Sequencer: clear sweep, then one request at a time in two steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            // A finished request refills the response register; otherwise it
            // empties once the response is taken.
            if (go)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                cur_reg <= q_ent;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == COL_W'(COL_COUNT - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.in_range        = out_reg.in_range;
    assign rsp.cell_type       = out_reg.cell_type;
    assign rsp.lit             = out_reg.lit;
    assign rsp.written         = out_reg.written;
    assign rsp.light_changed   = out_reg.light_changed;
    assign rsp.light_span_low  = out_reg.light_span_low;
    assign rsp.light_span_high = out_reg.light_span_high;

endmodule

>>> src/voxel_grid_with_column_light_depth.sv
`timescale 1ns / 1ps

// Voxel grid of X_SIZE x Y_SIZE x Z_SIZE 8-bit cell types with a light depth
// per (x,z) column. Each column lives in one memory word of Y_SIZE cells, so
// a request costs one memory read followed by one modify, depth encode and
// write-back: the column is read as its request leaves the queue, and written
// back once the output register can take the response. Up to two requests
// wait in a queue, and a finished response sits in an output register while
// the next request is worked on. After reset the block runs a clearing pass
// over all X_SIZE * Z_SIZE columns (65536 at the default size), writing air
// into every column; no request is taken until it ends.
// The column light depth is recomputed from the column word on every request.
module voxel_grid_with_column_light_depth
    import vgl_pkg::*;
#(
    parameter int X_SIZE = X_SIZE_DEF,
    parameter int Y_SIZE = Y_SIZE_DEF,
    parameter int Z_SIZE = Z_SIZE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    vgl_cmd_if.sink   cmd,
    vgl_rsp_if.source rsp
);

    localparam int YIDX_W = $clog2(Y_SIZE);
    localparam int COL_W  = $clog2(X_SIZE * Z_SIZE);
    localparam int ENT_W  = 2 + YIDX_W + COL_W + TYPE_W;

    logic             clearing;
    logic             q_full;
    logic             q_push;
    logic [ENT_W-1:0] q_in;
    logic             q_pop;
    logic             q_valid;
    logic [ENT_W-1:0] q_out;

    // Front end: range check and column addressing.
    vgl_front #(
        .X_SIZE (X_SIZE),
        .Y_SIZE (Y_SIZE),
        .Z_SIZE (Z_SIZE)
    ) u_front (
        .cmd      (cmd),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // Request queue between the two halves.
    vgl_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    // Back end: column memory, read-modify-write and response register.
    vgl_back #(
        .X_SIZE (X_SIZE),
        .Y_SIZE (Y_SIZE),
        .Z_SIZE (Z_SIZE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .clearing (clearing),
        .rsp      (rsp)
    );

`ifndef SYNTH
    // No request may enter while the store is being cleared.
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |-> !clearing
    ) else $error("request accepted during clearing pass");

    // An out-of-range response reads as lit air.
    a_out_of_range_response: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.in_range) |-> (rsp.cell_type == '0 && rsp.lit && !rsp.written)
    ) else $error("out-of-range response carries cell data");

    // The light depth can only move when a cell was actually written.
    a_change_needs_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.light_changed) |-> rsp.written
    ) else $error("light change reported without a write");

    // The queue and the response register stay empty while the back end sweeps.
    a_queue_empty_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> (!q_valid && !rsp.valid)
    ) else $error("work pending during clearing pass");
`endif

endmodule
